// ===== rtl/psu_pkg.sv =====
// Package for the PNG scanline unfilter block.
// Holds the filter type codes, register indexes and fixed field widths.
// No dependencies.
package psu_pkg;

	localparam int DATA_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int WIDTH_W   = 13;
	localparam int HEIGHT_W  = 16;
	localparam int ROW_W     = 16;
	localparam int CH_W      = 2;
	localparam int CH_MAX    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RGB    = 2'd2;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	localparam logic [DATA_W-1:0] FILT_MAX_CODE = 8'd4;

endpackage

// ===== rtl/png_scanline_unfilter_top.sv =====
// PNG scanline unfilter: rebuilds None/Sub/Up/Average/Paeth filtered bytes.
// A result passes through stage 1 and the output register before it is valid.
// Throughput: one byte per cycle unless the output stalls; the previous-row
// buffer is one memory with a registered read port at acceptance and a write
// port one stage later. Reset (arst_n low) clears counters, filter state and
// valid flags; the row buffer is not cleared, the first row ignores its reads.
module png_scanline_unfilter_top #(
	parameter int MAX_PIXELS_PER_ROW  = 4096,
	parameter int MAX_BYTES_PER_PIXEL = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psu_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] data_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,  // [7:0] pixel_byte
	output logic                           m_tlast,  // row_end
	output logic [1:0]                     m_tuser   // [0] bad_filter, [1] image_end
);

	localparam int DEPTH   = MAX_PIXELS_PER_ROW * MAX_BYTES_PER_PIXEL;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W   = $clog2(DEPTH + 1);
	localparam int RGB_BPP = (MAX_BYTES_PER_PIXEL < 3) ? MAX_BYTES_PER_PIXEL : 3;

	// Configuration registers.
	logic [psu_pkg::WIDTH_W-1:0]  width_q;
	logic [psu_pkg::HEIGHT_W-1:0] height_q;
	logic                         rgb_q;

	// Input-side row tracking.
	logic [COL_W-1:0]             byte_column_q;
	logic [psu_pkg::ROW_W-1:0]    row_index_q;
	psu_pkg::filter_t             filter_q;
	logic                         bad_q;
	logic [psu_pkg::CH_W-1:0]     chan_q;

	// Stage 1.
	logic                         valid_s1;
	logic [7:0]                   x_s1;
	logic [ADDR_W-1:0]            addr_s1;
	logic [psu_pkg::CH_W-1:0]     k_s1;
	logic                         has_left_s1;
	logic                         has_up_s1;
	psu_pkg::filter_t             filter_s1;
	logic                         bad_s1;
	logic                         row_end_s1;
	logic                         image_end_s1;
	logic [7:0]                   rd_data_s1;

	logic [7:0] prior_row_q [DEPTH];
	logic [7:0] left_q      [psu_pkg::CH_MAX];
	logic [7:0] upleft_q    [psu_pkg::CH_MAX];

	// Output register.
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_bad_q;
	logic                         out_row_end_q;
	logic                         out_image_end_q;

	logic                         s_fire;
	logic                         adv_s1;
	logic                         is_filter_byte;
	logic [16:0]                  width_eff;
	logic [COL_W-1:0]             row_bytes;
	logic [psu_pkg::HEIGHT_W-1:0] height_eff;
	logic [COL_W-1:0]             col;
	logic [COL_W-1:0]             bpp;
	logic [psu_pkg::CH_W-1:0]     k;
	logic                         last_in_row;
	logic                         last_row;
	logic [7:0]                   a_v, b_v, c_v, pred, val;
	logic signed [9:0]            pa, pb, pc;
	logic [8:0]                   pa_abs, pb_abs, pc_abs;
	logic [8:0]                   avg_sum;

	assign adv_s1         = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready       = !valid_s1 || adv_s1;
	assign s_fire         = s_tvalid && s_tready;
	assign is_filter_byte = (byte_column_q == '0);

	// Effective geometry from the registers.
	always_comb begin
		width_eff = {4'd0, width_q};
		if (width_eff == 17'd0) begin
			width_eff = 17'd1;
		end
		if (width_eff > 17'(MAX_PIXELS_PER_ROW)) begin
			width_eff = 17'(MAX_PIXELS_PER_ROW);
		end
		bpp        = rgb_q ? COL_W'(RGB_BPP) : COL_W'(1);
		row_bytes  = COL_W'(width_eff * (rgb_q ? RGB_BPP : 1));
		height_eff = (height_q == '0) ? psu_pkg::HEIGHT_W'(1) : height_q;
		col        = byte_column_q - COL_W'(1);
		k          = rgb_q ? chan_q : '0;
		// byte_column is one past the data column, so it equals col + 1.
		last_in_row = (byte_column_q >= row_bytes);
		last_row    = last_in_row &&
			(({1'b0, row_index_q} + 17'd1) >= {1'b0, height_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= psu_pkg::WIDTH_W'(1);
			height_q <= psu_pkg::HEIGHT_W'(1);
			rgb_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				psu_pkg::REG_WIDTH:  width_q  <= cfg_data[psu_pkg::WIDTH_W-1:0];
				psu_pkg::REG_HEIGHT: height_q <= cfg_data[psu_pkg::HEIGHT_W-1:0];
				psu_pkg::REG_RGB:    rgb_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_column_q <= '0;
			row_index_q   <= '0;
			filter_q      <= psu_pkg::FILT_NONE;
			bad_q         <= 1'b0;
			chan_q        <= '0;
		end else if (s_fire) begin
			if (is_filter_byte) begin
				if (s_tdata > psu_pkg::FILT_MAX_CODE) begin
					filter_q <= psu_pkg::FILT_NONE;
					bad_q    <= 1'b1;
				end else begin
					filter_q <= psu_pkg::filter_t'(s_tdata[2:0]);
					bad_q    <= 1'b0;
				end
				byte_column_q <= COL_W'(1);
				chan_q        <= '0;
			end else if (last_in_row) begin
				byte_column_q <= '0;
				row_index_q   <= last_row ? '0 : row_index_q + psu_pkg::ROW_W'(1);
			end else begin
				byte_column_q <= byte_column_q + COL_W'(1);
				chan_q <= (chan_q == psu_pkg::CH_W'(RGB_BPP - 1)) ? '0
					: chan_q + psu_pkg::CH_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= !is_filter_byte;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && !is_filter_byte) begin
			x_s1         <= s_tdata;
			addr_s1      <= col[ADDR_W-1:0];
			k_s1         <= k;
			has_left_s1  <= (col >= bpp);
			has_up_s1    <= (row_index_q != '0);
			filter_s1    <= filter_q;
			bad_s1       <= bad_q;
			row_end_s1   <= last_in_row;
			image_end_s1 <= last_row;
		end
	end

	// Row buffer: read at acceptance, written back when stage 1 moves on.
	// Within a row the columns differ, and a row start follows a filter byte,
	// so a read never meets the pending write to the same entry.
	always_ff @(posedge clk) begin
		if (s_fire && !is_filter_byte) begin
			rd_data_s1 <= prior_row_q[col[ADDR_W-1:0]];
		end
		if (adv_s1) begin
			prior_row_q[addr_s1] <= val;
		end
	end

	always_comb begin
		a_v = has_left_s1 ? left_q[k_s1] : 8'd0;
		b_v = has_up_s1 ? rd_data_s1 : 8'd0;
		c_v = (has_left_s1 && has_up_s1) ? upleft_q[k_s1] : 8'd0;

		// Paeth distances from p = a + b - c.
		pa = $signed({2'b00, b_v}) - $signed({2'b00, c_v});
		pb = $signed({2'b00, a_v}) - $signed({2'b00, c_v});
		pc = pa + pb;
		pa_abs = pa[9] ? 9'(-pa) : pa[8:0];
		pb_abs = pb[9] ? 9'(-pb) : pb[8:0];
		pc_abs = pc[9] ? 9'(-pc) : pc[8:0];
		avg_sum = {1'b0, a_v} + {1'b0, b_v};

		case (filter_s1)
			psu_pkg::FILT_SUB: pred = a_v;
			psu_pkg::FILT_UP:  pred = b_v;
			psu_pkg::FILT_AVG: pred = avg_sum[8:1];
			psu_pkg::FILT_PAETH: begin
				if (pa_abs <= pb_abs && pa_abs <= pc_abs) begin
					pred = a_v;
				end else if (pb_abs <= pc_abs) begin
					pred = b_v;
				end else begin
					pred = c_v;
				end
			end
			default: pred = 8'd0;
		endcase
		val = x_s1 + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psu_pkg::CH_MAX; i++) begin
				left_q[psu_pkg::CH_W'(i)]   <= 8'd0;
				upleft_q[psu_pkg::CH_W'(i)] <= 8'd0;
			end
		end else if (adv_s1) begin
			left_q[k_s1]   <= val;
			upleft_q[k_s1] <= b_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_byte_q      <= val;
			out_bad_q       <= bad_s1;
			out_row_end_q   <= row_end_s1;
			out_image_end_q <= image_end_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_row_end_q;
	assign m_tuser  = {out_image_end_q, out_bad_q};

	// A stalled stage 1 keeps its item and, on rows that use it, its row-buffer data.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(addr_s1) &&
			(!has_up_s1 || $stable(rd_data_s1)))
		else $error("stage 1 lost its item while stalled");

	// A filter byte never produces a result.
	a_filter_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && is_filter_byte |=> !valid_s1)
		else $error("filter byte entered stage 1");

	// The end of the image is always also the end of a row.
	a_image_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && image_end_s1 |-> row_end_s1)
		else $error("image end without row end");

	// The channel counter stays below the RGB pixel size.
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q < psu_pkg::CH_W'(RGB_BPP) || chan_q == '0)
		else $error("channel counter out of range");

	// After a row end is accepted the next input byte is a filter byte.
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !is_filter_byte && last_in_row |=> is_filter_byte)
		else $error("row did not restart after its last byte");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for png_scanline_unfilter_top: streams filtered rows in,
// rebuilds every byte in a local copy of the reconstruction rules and compares.
// Depends on psu_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_PIX = 4096;
	localparam logic [psu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] pixel;
		logic       bad;
		logic       row_end;
		logic       image_end;
	} pixel_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [psu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [psu_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [7:0]                    m_tdata;
	logic                          m_tlast;
	logic [1:0]                    m_tuser;

	// Local copy of the register file and the reconstruction state.
	bit [12:0] reg_width = 13'd1;
	bit [15:0] reg_height = 16'd1;
	bit        reg_rgb = 1'b0;
	bit [7:0]  prev_line [0:MAX_PIX*3-1];
	bit [15:0] line_no = '0;
	bit [13:0] col_pos = '0;
	psu_pkg::filter_t line_filter = psu_pkg::FILT_NONE;
	bit        line_bad = 1'b0;
	bit [7:0]  left_px [0:2];
	bit [7:0]  upleft_px [0:2];

	pixel_t rebuilt_q [$];
	int     mismatches = 0;
	bit     src_gaps = 1'b1;
	logic   sink_gaps = 1'b1;
	logic   sink_hold = 1'b0;
	int     stall_left = 0;

	png_scanline_unfilter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int line_bytes();
		int w;
		w = (reg_width == 0) ? 1 : ((reg_width > MAX_PIX) ? MAX_PIX : int'(reg_width));
		return reg_rgb ? 3 * w : w;
	endfunction

	function automatic int line_count();
		return (reg_height == 0) ? 1 : int'(reg_height);
	endfunction

	// Rebuilds one accepted byte; a filter type byte only sets up the row.
	function automatic void unfilter_byte(input bit [7:0] x);
		int bpp, col, k, a, b, c, pred, p, pa, pb, pc;
		bit last_col, last_line;
		pixel_t px;
		bpp = reg_rgb ? 3 : 1;
		if (col_pos == 0) begin
			line_bad = (x > psu_pkg::FILT_MAX_CODE);
			line_filter = line_bad ? psu_pkg::FILT_NONE : psu_pkg::filter_t'(x[2:0]);
			col_pos = 14'd1;
			return;
		end
		col = int'(col_pos) - 1;
		k = col % bpp;
		a = (col >= bpp) ? int'(left_px[2'(k)]) : 0;
		b = (line_no > 0) ? int'(prev_line[14'(col)]) : 0;
		c = (col >= bpp && line_no > 0) ? int'(upleft_px[2'(k)]) : 0;
		case (line_filter)
			psu_pkg::FILT_SUB: pred = a;
			psu_pkg::FILT_UP: pred = b;
			psu_pkg::FILT_AVG: pred = (a + b) >> 1;
			psu_pkg::FILT_PAETH: begin
				p = a + b - c;
				pa = (p > a) ? p - a : a - p;
				pb = (p > b) ? p - b : b - p;
				pc = (p > c) ? p - c : c - p;
				if (pa <= pb && pa <= pc)
					pred = a;
				else if (pb <= pc)
					pred = b;
				else
					pred = c;
			end
			default: pred = 0;
		endcase
		px.pixel = 8'(int'(x) + pred);
		upleft_px[2'(k)] = 8'(b);
		left_px[2'(k)] = px.pixel;
		prev_line[14'(col)] = px.pixel;
		last_col = (col + 1) >= line_bytes();
		last_line = last_col && (int'(line_no) + 1) >= line_count();
		px.bad = line_bad;
		px.row_end = last_col;
		px.image_end = last_line;
		rebuilt_q.push_back(px);
		if (last_col) begin
			col_pos = 0;
			line_no = last_line ? 16'd0 : line_no + 16'd1;
		end else begin
			col_pos = col_pos + 14'd1;
		end
	endfunction

	function automatic bit [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly legal filter types, now and then an unknown one.
	function automatic bit [7:0] pick_filter();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(int'(psu_pkg::FILT_MAX_CODE) + 1, 255));
		return 8'($urandom_range(int'(psu_pkg::FILT_NONE), int'(psu_pkg::FILT_PAETH)));
	endfunction

	task automatic send_byte(input bit [7:0] b);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		unfilter_byte(b);
	endtask

	task automatic send_line(input bit [7:0] ftype, input int n);
		send_byte(ftype);
		repeat (n) send_byte(pick_byte());
	endtask

	// Waits for every expected transfer out, then lets the pipeline empty.
	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (rebuilt_q.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [psu_pkg::CFG_IDX_W-1:0] idx,
			input logic [psu_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			psu_pkg::REG_WIDTH: reg_width = val[12:0];
			psu_pkg::REG_HEIGHT: reg_height = val;
			psu_pkg::REG_RGB: reg_rgb = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_reset_values();
		// One gray pixel per row and one row per image until written.
		send_byte(8'(psu_pkg::FILT_NONE));
		send_byte(8'hFF);
		send_byte(8'h05);
		send_byte(8'h00);
		settle();
		write_reg(REG_UNUSED, 16'hFFFF);
		send_byte(8'(psu_pkg::FILT_AVG));
		send_byte(8'h77);
	endtask

	task automatic test_filter_types();
		bit [7:0] seq [15] = '{
			8'(psu_pkg::FILT_SUB), 8'h01, 8'hFF,
			8'(psu_pkg::FILT_UP), 8'h80, 8'h80,
			8'(psu_pkg::FILT_AVG), 8'hFF, 8'hFF,
			8'(psu_pkg::FILT_PAETH), 8'h00, 8'h7F,
			8'hFF, 8'h12, 8'h34
		};
		settle();
		write_reg(psu_pkg::REG_WIDTH, 16'd2);
		write_reg(psu_pkg::REG_HEIGHT, 16'd5);
		write_reg(psu_pkg::REG_RGB, 16'd0);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	task automatic test_resize_mid_image();
		bit [7:0] head [8] = '{
			8'(psu_pkg::FILT_SUB), 8'h10, 8'h20,
			8'(psu_pkg::FILT_PAETH), 8'h30, 8'h40,
			8'(psu_pkg::FILT_UP), 8'h50
		};
		settle();
		write_reg(psu_pkg::REG_WIDTH, 16'd2);
		write_reg(psu_pkg::REG_HEIGHT, 16'hFFFF);
		write_reg(psu_pkg::REG_RGB, 16'd0);
		foreach (head[i]) send_byte(head[i]);
		// Narrowing the row and the image here makes the next byte end both.
		settle();
		write_reg(psu_pkg::REG_WIDTH, 16'd1);
		write_reg(psu_pkg::REG_HEIGHT, 16'd2);
		send_byte(8'h60);
		send_byte(8'(psu_pkg::FILT_AVG));
		send_byte(8'h70);
		send_byte(8'(psu_pkg::FILT_UP));
		send_byte(8'h80);
	endtask

	task automatic test_output_stall();
		settle();
		write_reg(psu_pkg::REG_WIDTH, 16'd5);
		write_reg(psu_pkg::REG_HEIGHT, 16'd3);
		write_reg(psu_pkg::REG_RGB, 16'd0);
		src_gaps = 1'b0;
		fork
			begin
				sink_hold <= 1'b1;
				repeat (300) @(posedge clk);
				sink_hold <= 1'b0;
			end
			repeat (3 * line_count()) send_line(pick_filter(), line_bytes());
		join
		src_gaps = 1'b1;
	endtask

	task automatic test_random_images();
		int sent, w;
		sent = 0;
		while (sent < 1250) begin
			settle();
			src_gaps = ($urandom_range(0, 3) != 0);
			sink_gaps <= ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: w = 0;
				1, 2: w = $urandom_range(9, 24);
				default: w = $urandom_range(1, 8);
			endcase
			write_reg(psu_pkg::REG_WIDTH, {3'($urandom), 13'(w)});
			write_reg(psu_pkg::REG_HEIGHT, 16'($urandom_range(0, 6)));
			write_reg(psu_pkg::REG_RGB, 16'($urandom));
			repeat ($urandom_range(1, 3) * line_count()) begin
				send_line(pick_filter(), line_bytes());
				sent += line_bytes() + 1;
			end
		end
	endtask

	task automatic test_widest_rows();
		settle();
		src_gaps = 1'b0;
		sink_gaps <= 1'b0;
		// An all-ones width saturates to the widest row, so no row end comes early.
		write_reg(psu_pkg::REG_WIDTH, 16'hFFFF);
		write_reg(psu_pkg::REG_HEIGHT, 16'd2);
		write_reg(psu_pkg::REG_RGB, 16'hFFFF);
		send_line(pick_filter(), 240);
		// Narrowing the row now makes the next byte its last.
		settle();
		write_reg(psu_pkg::REG_WIDTH, 16'd1);
		send_byte(pick_byte());
		send_line(8'(psu_pkg::FILT_PAETH), line_bytes());
	endtask

	always @(posedge clk) begin
		if (sink_hold) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rebuilt_q.size() == 0) begin
				$error("unexpected transfer out: pixel_byte %02h", m_tdata);
				mismatches++;
			end else begin
				want = rebuilt_q.pop_front();
				if (m_tdata !== want.pixel) begin
					$error("pixel_byte: expected %02h, got %02h", want.pixel, m_tdata);
					mismatches++;
				end
				if (m_tuser[0] !== want.bad) begin
					$error("bad_filter: expected %0b, got %0b", want.bad, m_tuser[0]);
					mismatches++;
				end
				if (m_tlast !== want.row_end) begin
					$error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
					mismatches++;
				end
				if (m_tuser[1] !== want.image_end) begin
					$error("image_end: expected %0b, got %0b", want.image_end, m_tuser[1]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("png_scanline_unfilter_top: mismatch");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_filter_types();
		test_resize_mid_image();
		test_output_stall();
		test_random_images();
		test_widest_rows();
		settle();
		if (rebuilt_q.size() != 0) begin
			$error("%0d expected transfers never came out", rebuilt_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("png_scanline_unfilter_top: match");
		else
			$display("png_scanline_unfilter_top: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/psu_pkg.sv
rtl/png_scanline_unfilter_top.sv
bench/testbench.sv
